// File: src/mrme_pkg.sv
package mrme_pkg;

    typedef enum logic [1:0] {
        OP_APPEND    = 2'd0,
        OP_ADD       = 2'd1,
        OP_NORMALIZE = 2'd2,
        OP_READ      = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_CARVE_RD,
        S_CARVE_EVAL,
        S_SHIFT,
        S_SORT_RD,
        S_SORT_EVAL,
        S_MERGE_RD,
        S_MERGE_EVAL,
        S_COMMIT,
        S_DONE
    } state_t;

endpackage

// File: src/memory_range_map_engine.sv
// Output: append and read pass S_RD_WAIT, then S_DONE, which registers m_axis_tvalid.
// Add and normalize run on the working memory: copy the table in, carve (add only),
// insertion-sort by adjacent swaps, merge overlapping same-type entries; carve and
// merge move entries by shifting. The result is then copied back in S_COMMIT.
// Flow: one transaction at a time; s_axis_tready is high only when idle with no
// result waiting.
// Reset: aresetn synchronous active low clears count and control, not the entry memories.
module memory_range_map_engine
    import mrme_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: opcode[1:0], range_type[33:2], base_addr[97:34],
    // range_size[161:98], entry_index[167:162]
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: status[1:0], entry_count[8:2], read_start[72:9],
    // read_size[136:73], read_type[168:137]
    output logic [175:0] m_axis_tdata
);
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = 160;

    // table and working copy; entry = {type, size, start}
    logic [EW-1:0] tbl_mem [MAX_ENTRIES];
    logic [EW-1:0] wk_mem  [MAX_ENTRIES];

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, wn_reg;
    logic [1:0]   op_reg;
    logic [31:0]  typ_reg;
    logic [63:0]  s_reg, e_reg, z_reg;
    logic [5:0]   idx_reg;
    logic [CW-1:0] i_reg, j_reg, k_reg;
    logic [EW-1:0] a_reg, b_reg, rd_reg;
    logic [1:0]   status_reg;
    logic         ovf_reg;
    logic [175:0] out_reg;
    logic         out_valid_reg;
    // shift direction: 1 = open gap at i+1 (move up), 0 = close gap at k (move down)
    logic         up_reg;
    state_t       ret_reg;
    logic         copy_reg;

    logic [63:0] a_s, a_z, a_e, b_s, b_z, b_e;
    assign a_s = a_reg[63:0];
    assign a_z = a_reg[127:64];
    assign a_e = a_s + a_z;
    assign b_s = b_reg[63:0];
    assign b_z = b_reg[127:64];
    assign b_e = b_s + b_z;

    logic in_acc;
    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg;

    logic do_copy, wk_full, carve_del, carve_split, merge_hit;
    assign do_copy = copy_reg && (opcode_t'(op_reg) == OP_ADD ||
                                  opcode_t'(op_reg) == OP_NORMALIZE);
    assign wk_full = 32'(wn_reg) >= 32'(MAX_ENTRIES);
    assign carve_del = s_reg <= a_s && e_reg >= a_e;
    assign carve_split = s_reg > a_s && e_reg < a_e;
    assign merge_hit = a_reg[159:128] == b_reg[159:128] && a_s <= b_s && a_e > b_s;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_acc) state_next = S_RD_WAIT;
            S_RD_WAIT: begin
                if (!do_copy)
                    state_next = S_DONE;
                else if (i_reg >= cnt_reg)
                    state_next = (opcode_t'(op_reg) == OP_ADD) ? S_CARVE_RD : S_SORT_RD;
            end
            S_CARVE_RD: begin
                if (i_reg < wn_reg)
                    state_next = S_CARVE_EVAL;
                else if (wk_full)
                    state_next = S_DONE;
                else
                    state_next = S_SORT_RD;
            end
            S_CARVE_EVAL: begin
                if (carve_del)
                    state_next = S_SHIFT;
                else if (carve_split)
                    state_next = wk_full ? S_DONE : S_SHIFT;
                else
                    state_next = S_CARVE_RD;
            end
            S_SHIFT: begin
                if (up_reg) begin
                    if (!(k_reg > i_reg + 1'b1)) state_next = ret_reg;
                end else if (!(k_reg + 1'b1 < wn_reg)) begin
                    state_next = ret_reg;
                end
            end
            S_SORT_RD:    state_next = (i_reg < wn_reg) ? S_SORT_EVAL : S_MERGE_RD;
            S_SORT_EVAL:  if (!(a_s > b_s) || j_reg <= CW'(1)) state_next = S_SORT_RD;
            S_MERGE_RD:   state_next = (i_reg + 1'b1 < wn_reg) ? S_MERGE_EVAL : S_COMMIT;
            S_MERGE_EVAL: state_next = merge_hit ? S_SHIFT : S_MERGE_RD;
            S_COMMIT:     if (i_reg >= wn_reg) state_next = S_DONE;
            S_DONE:       state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // single sequencer; some states read or write two working-memory entries at once
    always_ff @(posedge aclk) begin
        logic [EW-1:0] ent;
        logic [63:0] ne;
        ent = '0;
        ne = '0;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            else if (state_reg == S_DONE)
                out_valid_reg <= 1'b1;
            unique case (state_reg)
                S_IDLE: if (in_acc) begin
                    op_reg  <= s_axis_tdata[1:0];
                    typ_reg <= s_axis_tdata[33:2];
                    s_reg   <= s_axis_tdata[97:34];
                    z_reg   <= s_axis_tdata[161:98];
                    e_reg   <= s_axis_tdata[97:34] + s_axis_tdata[161:98];
                    idx_reg <= s_axis_tdata[167:162];
                    rd_reg  <= tbl_mem[IW'(s_axis_tdata[167:162])];
                    status_reg <= ST_OK;
                    i_reg <= '0;
                    wn_reg <= cnt_reg;
                    ovf_reg <= 1'b0;
                    copy_reg <= 1'b1;
                end
                S_RD_WAIT: begin
                    if (do_copy) begin
                        // copy table into working memory
                        if (i_reg < cnt_reg) begin
                            wk_mem[i_reg[IW-1:0]] <= tbl_mem[i_reg[IW-1:0]];
                            i_reg <= i_reg + 1'b1;
                        end else begin
                            copy_reg <= 1'b0;
                            i_reg <= (opcode_t'(op_reg) == OP_ADD) ? CW'(0) : CW'(1);
                        end
                    end else begin
                        priority case (opcode_t'(op_reg))
                            OP_APPEND: begin
                                if (32'(cnt_reg) >= 32'(MAX_ENTRIES))
                                    status_reg <= ST_FULL;
                                else begin
                                    tbl_mem[cnt_reg[IW-1:0]] <= {typ_reg, z_reg, s_reg};
                                    cnt_reg <= cnt_reg + 1'b1;
                                end
                            end
                            OP_READ: begin
                                if (32'(idx_reg) >= 32'(cnt_reg)) begin
                                    status_reg <= ST_BAD_INDEX;
                                    rd_reg <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CARVE_RD: begin
                    if (i_reg < wn_reg) begin
                        a_reg <= wk_mem[i_reg[IW-1:0]];
                    end else if (wk_full) begin
                        status_reg <= ST_FULL;
                    end else begin
                        wk_mem[wn_reg[IW-1:0]] <= {typ_reg, z_reg, s_reg};
                        wn_reg <= wn_reg + 1'b1;
                        i_reg <= CW'(1);
                    end
                end
                S_CARVE_EVAL: begin
                    if (carve_del) begin
                        // delete: close gap at i
                        up_reg <= 1'b0;
                        k_reg <= i_reg;
                        ret_reg <= S_CARVE_RD;
                    end else if (carve_split) begin
                        if (wk_full) begin
                            status_reg <= ST_FULL;
                        end else begin
                            wk_mem[i_reg[IW-1:0]] <= {a_reg[159:128], s_reg - a_s, a_s};
                            b_reg <= {a_reg[159:128], a_e - e_reg, e_reg};
                            up_reg <= 1'b1;
                            k_reg <= wn_reg;
                            ret_reg <= S_CARVE_RD;
                        end
                    end else begin
                        if (s_reg <= a_s && e_reg > a_s)
                            wk_mem[i_reg[IW-1:0]] <= {a_reg[159:128], a_e - e_reg, e_reg};
                        else if (s_reg < a_e && s_reg > a_s)
                            wk_mem[i_reg[IW-1:0]] <= {a_reg[159:128], s_reg - a_s, a_s};
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_SHIFT: begin
                    if (up_reg) begin
                        // move entries k-1 -> k down to i+1, then put b at i+1
                        if (k_reg > i_reg + 1'b1) begin
                            wk_mem[k_reg[IW-1:0]] <= wk_mem[IW'(k_reg - 1'b1)];
                            k_reg <= k_reg - 1'b1;
                        end else begin
                            wk_mem[IW'(i_reg + 1'b1)] <= b_reg;
                            wn_reg <= wn_reg + 1'b1;
                            i_reg <= i_reg + CW'(2);
                        end
                    end else begin
                        if (k_reg + 1'b1 < wn_reg) begin
                            wk_mem[k_reg[IW-1:0]] <= wk_mem[IW'(k_reg + 1'b1)];
                            k_reg <= k_reg + 1'b1;
                        end else begin
                            wn_reg <= wn_reg - 1'b1;
                        end
                    end
                end
                S_SORT_RD: begin
                    // insertion sort by adjacent swaps: j walks down
                    if (i_reg < wn_reg) begin
                        j_reg <= i_reg;
                        a_reg <= wk_mem[IW'(i_reg - 1'b1)];
                        b_reg <= wk_mem[i_reg[IW-1:0]];
                    end else begin
                        i_reg <= '0;
                    end
                end
                S_SORT_EVAL: begin
                    if (a_s > b_s) begin
                        wk_mem[j_reg[IW-1:0]] <= a_reg;
                        wk_mem[IW'(j_reg - 1'b1)] <= b_reg;
                        if (j_reg > CW'(1)) begin
                            a_reg <= wk_mem[IW'(j_reg - CW'(2))];
                            j_reg <= j_reg - 1'b1;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_MERGE_RD: begin
                    if (i_reg + 1'b1 < wn_reg) begin
                        a_reg <= wk_mem[i_reg[IW-1:0]];
                        b_reg <= wk_mem[IW'(i_reg + 1'b1)];
                    end else begin
                        i_reg <= '0;
                    end
                end
                S_MERGE_EVAL: begin
                    if (merge_hit) begin
                        ne = (a_e < b_e) ? b_e : a_e;
                        wk_mem[i_reg[IW-1:0]] <= {a_reg[159:128], ne - a_s, a_s};
                        up_reg <= 1'b0;
                        k_reg <= i_reg + 1'b1;
                        ret_reg <= S_MERGE_RD;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_COMMIT: begin
                    if (i_reg < wn_reg) begin
                        tbl_mem[i_reg[IW-1:0]] <= wk_mem[i_reg[IW-1:0]];
                        i_reg <= i_reg + 1'b1;
                    end else begin
                        cnt_reg <= wn_reg;
                    end
                end
                S_DONE: begin
                    ent = (opcode_t'(op_reg) == OP_READ) ? rd_reg : '0;
                    out_reg <= {7'd0, ent[159:128], ent[127:64], ent[63:0],
                                7'(cnt_reg), status_reg};
                end
                default: ;
            endcase
        end
    end
endmodule

// File: tb/sv/tb_memory_range_map_engine.sv
module tb_memory_range_map_engine
    import mrme_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ENTRIES = 64;
    localparam int RANDOM_ITEMS = 1600;
    localparam longint CYCLE_LIMIT = 64'd200_000_000;

    typedef struct packed {
        logic [5:0]  entry_index;
        logic [63:0] range_size;
        logic [63:0] base_addr;
        logic [31:0] range_type;
        opcode_t     opcode;
    } map_cmd_t;

    typedef struct packed {
        logic [6:0]  pad;
        logic [31:0] read_type;
        logic [63:0] read_size;
        logic [63:0] read_start;
        logic [6:0]  entry_count;
        status_t     status;
    } map_rsp_t;

    class map_scoreboard;
        logic [63:0] starts[NUM_ENTRIES];
        logic [63:0] sizes[NUM_ENTRIES];
        logic [31:0] types[NUM_ENTRIES];
        int          count;
        map_rsp_t    pending[$];
        int          errors;
        int          checked;

        // scratch table for add and normalize
        logic [63:0] ws[NUM_ENTRIES];
        logic [63:0] wz[NUM_ENTRIES];
        logic [31:0] wt[NUM_ENTRIES];
        int          wn;

        function void drop_entry(int i);
            for (int k = i; k + 1 < wn; k++) begin
                ws[k] = ws[k+1]; wz[k] = wz[k+1]; wt[k] = wt[k+1];
            end
            wn--;
        endfunction

        function void sort_and_merge();
            int j;
            int i;
            logic [63:0] s, z, ae, be;
            logic [31:0] t;
            for (int n = 1; n < wn; n++) begin
                s = ws[n]; z = wz[n]; t = wt[n];
                j = n;
                while (j > 0 && ws[j-1] > s) begin
                    ws[j] = ws[j-1]; wz[j] = wz[j-1]; wt[j] = wt[j-1];
                    j--;
                end
                ws[j] = s; wz[j] = z; wt[j] = t;
            end
            i = 0;
            while (i + 1 < wn) begin
                ae = ws[i] + wz[i];
                be = ws[i+1] + wz[i+1];
                if (wt[i] == wt[i+1] && ws[i] <= ws[i+1] && ae > ws[i+1]) begin
                    if (ae < be) ae = be;
                    wz[i] = ae - ws[i];
                    drop_entry(i + 1);
                end else begin
                    i++;
                end
            end
        endfunction

        // returns 1 when a split overflows the table
        function bit carve(logic [63:0] s, logic [63:0] z);
            logic [63:0] e, ms, me;
            int i;
            e = s + z;
            i = 0;
            while (i < wn) begin
                ms = ws[i];
                me = ms + wz[i];
                if (s <= ms && e >= me) begin
                    drop_entry(i);
                end else if (s > ms && e < me) begin
                    if (wn >= NUM_ENTRIES) return 1;
                    for (int k = wn; k > i + 1; k--) begin
                        ws[k] = ws[k-1]; wz[k] = wz[k-1]; wt[k] = wt[k-1];
                    end
                    wt[i+1] = wt[i];
                    wn++;
                    wz[i] = s - ms;
                    ws[i+1] = e;
                    wz[i+1] = me - e;
                    i += 2;
                end else begin
                    if (s <= ms && e > ms) begin
                        ws[i] = e;
                        wz[i] = me - e;
                    end else if (s < me && s > ms) begin
                        wz[i] = s - ms;
                    end
                    i++;
                end
            end
            return 0;
        endfunction

        function void note_command(map_cmd_t c);
            map_rsp_t r;
            r = '0;
            r.status = ST_OK;
            ws = starts; wz = sizes; wt = types; wn = count;
            case (c.opcode)
                OP_APPEND: begin
                    if (count >= NUM_ENTRIES) begin
                        r.status = ST_FULL;
                    end else begin
                        starts[count] = c.base_addr;
                        sizes[count] = c.range_size;
                        types[count] = c.range_type;
                        count++;
                    end
                end
                OP_ADD: begin
                    if (carve(c.base_addr, c.range_size) || wn >= NUM_ENTRIES) begin
                        r.status = ST_FULL;
                    end else begin
                        ws[wn] = c.base_addr; wz[wn] = c.range_size;
                        wt[wn] = c.range_type;
                        wn++;
                        sort_and_merge();
                        starts = ws; sizes = wz; types = wt; count = wn;
                    end
                end
                OP_NORMALIZE: begin
                    sort_and_merge();
                    starts = ws; sizes = wz; types = wt; count = wn;
                end
                default: begin
                    if (c.entry_index >= count) begin
                        r.status = ST_BAD_INDEX;
                    end else begin
                        r.read_start = starts[c.entry_index];
                        r.read_size = sizes[c.entry_index];
                        r.read_type = types[c.entry_index];
                    end
                end
            endcase
            r.entry_count = count[6:0];
            pending.push_back(r);
        endfunction

        function void check_result(map_rsp_t a);
            map_rsp_t x;
            checked++;
            if (pending.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            x = pending.pop_front();
            if (a.status !== x.status) begin
                $error("status: expected %0d, got %0d", x.status, a.status); errors++;
            end
            if (a.entry_count !== x.entry_count) begin
                $error("entry_count: expected %0d, got %0d", x.entry_count, a.entry_count);
                errors++;
            end
            if (a.read_start !== x.read_start) begin
                $error("read_start: expected %h, got %h", x.read_start, a.read_start);
                errors++;
            end
            if (a.read_size !== x.read_size) begin
                $error("read_size: expected %h, got %h", x.read_size, a.read_size); errors++;
            end
            if (a.read_type !== x.read_type) begin
                $error("read_type: expected %h, got %h", x.read_type, a.read_type); errors++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [175:0] m_axis_tdata;

    map_scoreboard board = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    longint cycles = 0;
    int  op_counts[4];
    logic [63:0] addr_pool[8];

    always #5 aclk = ~aclk;

    memory_range_map_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) board.check_result(map_rsp_t'(m_axis_tdata));
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // hold tvalid between back-to-back transactions; drop it only while idling
    task automatic send_command(map_cmd_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.note_command(c);
        op_counts[c.opcode]++;
    endtask

    function automatic map_cmd_t make_command(opcode_t op, logic [31:0] t, logic [63:0] s,
                                              logic [63:0] z, logic [5:0] idx);
        map_cmd_t c;
        c.opcode = op; c.range_type = t; c.base_addr = s;
        c.range_size = z; c.entry_index = idx;
        return c;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // well-formed ranges land near a few shared addresses so they overlap
    function automatic map_cmd_t random_command();
        map_cmd_t c;
        int r;
        r = $urandom_range(99);
        c.range_type = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(2);
        c.entry_index = (board.count > 0 && $urandom_range(3) != 0)
                        ? 6'($urandom_range(board.count - 1)) : 6'($urandom_range(63));
        if ($urandom_range(9) == 0) begin
            c.base_addr = rand64(); c.range_size = rand64();
        end else begin
            c.base_addr = addr_pool[$urandom_range(7)] + 64'($urandom_range(4096));
            c.range_size = 64'($urandom_range(8192));
        end
        if (board.count > 48)
            c.opcode = (r < 10) ? OP_APPEND : (r < 40) ? OP_ADD : (r < 70) ? OP_NORMALIZE : OP_READ;
        else
            c.opcode = (r < 25) ? OP_APPEND : (r < 60) ? OP_ADD : (r < 70) ? OP_NORMALIZE : OP_READ;
        return c;
    endfunction

    initial begin
        logic [63:0] ones;
        ones = '1;
        foreach (addr_pool[i]) addr_pool[i] = rand64() & 64'hFFFF_FFFF_FFFF_0000;
        addr_pool[0] = 64'd0;
        addr_pool[1] = 64'hFFFF_FFFF_FFFF_E000;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, then overlap and split cases
        send_command(make_command(OP_READ, '0, '0, '0, 6'd0));
        send_command(make_command(OP_NORMALIZE, '0, '0, '0, '0));
        send_command(make_command(OP_APPEND, 32'd1, 64'h1000, 64'h1000, '0));
        send_command(make_command(OP_APPEND, 32'd1, 64'h0800, 64'h1000, '0));
        send_command(make_command(OP_APPEND, 32'd1, 64'h2000, 64'h100, '0));
        send_command(make_command(OP_APPEND, 32'd2, 64'h1800, 64'h100, '0));
        send_command(make_command(OP_NORMALIZE, '0, '0, '0, '0));
        send_command(make_command(OP_ADD, 32'd3, 64'h1200, 64'h100, '0));
        send_command(make_command(OP_ADD, 32'd3, 64'h0700, 64'h200, '0));
        send_command(make_command(OP_ADD, 32'd3, 64'h2080, 64'h200, '0));
        send_command(make_command(OP_ADD, 32'hFFFF_FFFF, 64'h0, 64'h2000, '0));
        send_command(make_command(OP_ADD, 32'd5, ones, ones, 6'h3F));
        send_command(make_command(OP_APPEND, 32'd5, ones - 64'hF, 64'h20, '0));
        send_command(make_command(OP_APPEND, 32'd5, ones - 64'h7, 64'h40, '0));
        send_command(make_command(OP_NORMALIZE, '0, '0, '0, '0));
        for (int i = 0; i < 5; i++) send_command(make_command(OP_READ, '0, '0, '0, 6'(i)));
        send_command(make_command(OP_READ, '0, '0, '0, 6'h3F));
        // fill the table to the refusal point
        for (int i = 0; i < 66; i++)
            send_command(make_command(OP_APPEND, $urandom(), rand64(), rand64(), '0));
        send_command(make_command(OP_ADD, 32'd7, 64'h10, 64'h1, '0));
        send_command(make_command(OP_READ, '0, '0, '0, 6'h3F));
        send_command(make_command(OP_NORMALIZE, '0, '0, '0, '0));
        send_command(make_command(OP_READ, '0, '0, '0, 6'h3F));

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = (p == 1 || p == 3) ? (p == 1 ? 72 : 26) : 0;
            recv_stall_pct = (p == 2 || p == 3) ? (p == 2 ? 72 : 26) : 0;
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                if (board.count >= 56 && $urandom_range(7) == 0) begin
                    // shrink the table: cover everything with one range
                    send_command(make_command(OP_ADD, $urandom_range(2), '0, ones, '0));
                end else begin
                    send_command(random_command());
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Covered %0d appends, %0d adds, %0d normalizes, %0d reads; %0d results checked",
                 op_counts[0], op_counts[1], op_counts[2], op_counts[3], board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
